[rtl/opcd_pkg.sv]
// Package: packet types, result codes, register map and CRC helpers for the packet check/decode.
package opcd_pkg;

    localparam int CRC_BYTES  = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int CHAN_W     = 11;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR  = 2'd1;
    localparam logic [1:0] STATUS_ADDR_ERR = 2'd2;

    localparam logic [1:0] PKT_RC   = 2'd0;
    localparam logic [1:0] PKT_MSP  = 2'd1;
    localparam logic [1:0] PKT_SYNC = 2'd2;
    localparam logic [1:0] PKT_TLM  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_OFFSET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_INDEX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UID_BYTE3   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UID_BYTE4   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UID_BYTE5   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_MODE = 3'd7;

    localparam logic [7:0] CRC_POLY_RESET = 8'h07;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] payload_byte1;
        logic [7:0] payload_byte2;
        logic [7:0] payload_byte3;
        logic [7:0] payload_byte4;
        logic [7:0] payload_byte5;
        logic [7:0] payload_byte6;
        logic [7:0] check_byte;
    } pkt_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [1:0]        packet_type;
        logic [CHAN_W-1:0] channel_0;
        logic [CHAN_W-1:0] channel_1;
        logic [CHAN_W-1:0] channel_2;
        logic [CHAN_W-1:0] channel_3;
        logic              sync_match;
        logic [7:0]        sync_hop_index;
        logic [7:0]        sync_nonce;
        logic [2:0]        sync_tlm_ratio;
        logic [7:0]        msp_function;
        logic [31:0]       msp_payload;
    } pkt_out_t;

    typedef struct packed {
        logic [7:0] crc_polynomial;
        logic [7:0] crc_offset;
        logic [5:0] device_address;
        logic [1:0] rate_index;
        logic [7:0] uid_byte3;
        logic [7:0] uid_byte4;
        logic [7:0] uid_byte5;
        logic [1:0] expected_switch_mode;
    } cfg_t;

    // one byte of MSB-first CRC-8, implicit top bit
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] pkt_byte(input pkt_in_t p, input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0: b = p.header_byte;
            3'd1: b = p.payload_byte1;
            3'd2: b = p.payload_byte2;
            3'd3: b = p.payload_byte3;
            3'd4: b = p.payload_byte4;
            3'd5: b = p.payload_byte5;
            3'd6: b = p.payload_byte6;
            3'd7: b = p.check_byte;
        endcase
        return b;
    endfunction

endpackage

[rtl/opcd_decode.sv]
// Final check and field decode: CRC compare, address compare, per-type unpacking.
module opcd_decode
    import opcd_pkg::*;
(
    input  pkt_in_t    pkt,
    input  logic [7:0] crc,
    input  cfg_t       cfg,
    output pkt_out_t   result
);

    logic [7:0] crc_adj;

    assign crc_adj = crc + cfg.crc_offset;

    always_comb
    begin
        result             = '0;
        result.packet_type = pkt.header_byte[1:0];
        priority if (crc_adj != pkt.check_byte)
        begin
            result.status = STATUS_CRC_ERR;
        end
        else if (pkt.header_byte[7:2] != cfg.device_address)
        begin
            result.status = STATUS_ADDR_ERR;
        end
        else
        begin
            result.status = STATUS_OK;
            unique case (pkt.header_byte[1:0])
                PKT_RC:
                begin
                    result.channel_0 = {pkt.payload_byte1, pkt.payload_byte5[7:5]};
                    result.channel_1 = {pkt.payload_byte2, pkt.payload_byte5[4:2]};
                    result.channel_2 = {pkt.payload_byte3, pkt.payload_byte5[1:0],
                                        pkt.payload_byte6[7]};
                    result.channel_3 = {pkt.payload_byte4, pkt.payload_byte6[6:4]};
                end
                PKT_MSP:
                begin
                    result.msp_function = pkt.payload_byte1;
                    result.msp_payload  = {pkt.payload_byte3, pkt.payload_byte4,
                                           pkt.payload_byte5, pkt.payload_byte6};
                end
                PKT_SYNC:
                begin
                    result.sync_hop_index = pkt.payload_byte1;
                    result.sync_nonce     = pkt.payload_byte2;
                    result.sync_tlm_ratio = pkt.payload_byte3[5:3];
                    result.sync_match     = (pkt.payload_byte3[7:6] == cfg.rate_index)
                                         && (pkt.payload_byte3[2:1] == cfg.expected_switch_mode)
                                         && (pkt.payload_byte4 == cfg.uid_byte3)
                                         && (pkt.payload_byte5 == cfg.uid_byte4)
                                         && (pkt.payload_byte6 == cfg.uid_byte5);
                end
                PKT_TLM:
                begin
                    result.status = STATUS_OK;
                end
            endcase
        end
    end

endmodule

[rtl/ota_packet_check_decode.sv]
// Top level: pipelined CRC-8 check and decode of 8-byte radio packets.
//
//   channel   signals                       request
//   in        in_valid/in_ready, in_data    one packet, bytes 0..7
//   out       out_valid/out_ready, out_data one status/decode result
//   cfg       cfg_we, cfg_index, cfg_wdata  register write, no wait
//
// One packet per cycle, unless out_ready stalls the pipe, through eight register
// stages: seven CRC stages (one byte each), then the decode/output register.
// Reset clears stage valid bits and loads register defaults.
// Each stage holds while the one after it is full and stalled; bubbles collapse.
module ota_packet_check_decode
    import opcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pkt_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pkt_out_t              out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t       cfg_reg;

    logic       vld_reg  [CRC_BYTES];
    pkt_in_t    pkt_reg  [CRC_BYTES];
    logic [7:0] crc_reg  [CRC_BYTES];
    logic [7:0] crc_next [CRC_BYTES];
    logic       stg_rdy  [CRC_BYTES+1];

    logic       out_valid_reg;
    pkt_out_t   out_data_reg;
    pkt_out_t   out_data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{crc_polynomial: CRC_POLY_RESET, default: '0};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CRC_POLY:    cfg_reg.crc_polynomial       <= cfg_wdata;
                REG_CRC_OFFSET:  cfg_reg.crc_offset           <= cfg_wdata;
                REG_DEV_ADDR:    cfg_reg.device_address       <= cfg_wdata[5:0];
                REG_RATE_INDEX:  cfg_reg.rate_index           <= cfg_wdata[1:0];
                REG_UID_BYTE3:   cfg_reg.uid_byte3            <= cfg_wdata;
                REG_UID_BYTE4:   cfg_reg.uid_byte4            <= cfg_wdata;
                REG_UID_BYTE5:   cfg_reg.uid_byte5            <= cfg_wdata;
                REG_SWITCH_MODE: cfg_reg.expected_switch_mode <= cfg_wdata[1:0];
            endcase
        end
    end

    assign stg_rdy[CRC_BYTES] = !out_valid_reg || out_ready;
    assign in_ready           = stg_rdy[0];

    for (genvar k = 0; k < CRC_BYTES; k++)
    begin : g_crc
        logic    src_vld;
        pkt_in_t src_pkt;
        logic [7:0] src_crc;

        if (k == 0)
        begin : g_first
            assign src_vld = in_valid;
            assign src_pkt = in_data;
            assign src_crc = 8'h00;
        end
        else
        begin : g_rest
            assign src_vld = vld_reg[k-1];
            assign src_pkt = pkt_reg[k-1];
            assign src_crc = crc_reg[k-1];
        end

        assign stg_rdy[k]  = !vld_reg[k] || stg_rdy[k+1];
        assign crc_next[k] = crc8_byte(src_crc, pkt_byte(src_pkt, 3'(k)),
                                       cfg_reg.crc_polynomial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (stg_rdy[k])
            begin
                vld_reg[k] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stg_rdy[k] && src_vld)
            begin
                pkt_reg[k] <= src_pkt;
                crc_reg[k] <= crc_next[k];
            end
        end
    end

    opcd_decode u_decode (
        .pkt    (pkt_reg[CRC_BYTES-1]),
        .crc    (crc_reg[CRC_BYTES-1]),
        .cfg    (cfg_reg),
        .result (out_data_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stg_rdy[CRC_BYTES])
        begin
            out_valid_reg <= vld_reg[CRC_BYTES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_rdy[CRC_BYTES] && vld_reg[CRC_BYTES-1])
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
